### rtl/core/flash_toggle_bit_program_erase_macros.svh
// ----------------------------------------------------------------------------
// flash toggle-bit sequencer assertion macros
// shared assertion wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef FLASH_TOGGLE_BIT_PROGRAM_ERASE_MACROS_SVH
`define FLASH_TOGGLE_BIT_PROGRAM_ERASE_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain property on clk, off during reset
`define FTB_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication on clk, off during reset
`define FTB_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define FTB_ASSERT(name, prop, msg)
`define FTB_ASSERT_IMPL(name, ante, cons, msg)

`endif

`endif

### rtl/core/ftb_pkg.sv
// ----------------------------------------------------------------------------
// ftb_pkg
// types and constants of the flash toggle-bit program/erase sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftb_pkg;

	localparam int ADDR_W = 24;
	localparam int DATA_W = 8;

	// command codes
	localparam logic [1:0] CMD_PROGRAM = 2'd0;
	localparam logic [1:0] CMD_ERASE   = 2'd1;
	localparam logic [1:0] CMD_STATUS  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// unlock cycle addresses and data
	localparam logic [ADDR_W-1:0] UNLOCK_ADDR1 = 24'h000AAA;
	localparam logic [ADDR_W-1:0] UNLOCK_ADDR2 = 24'h000555;
	localparam logic [DATA_W-1:0] UNLOCK_DATA1 = 8'hAA;
	localparam logic [DATA_W-1:0] UNLOCK_DATA2 = 8'h55;
	localparam logic [DATA_W-1:0] PROGRAM_DATA = 8'hA0;
	localparam logic [DATA_W-1:0] ERASE_SETUP  = 8'h80;
	localparam logic [DATA_W-1:0] ERASE_SECTOR = 8'h30;

	// irregular sector map
	localparam logic [DATA_W-1:0] SECTOR_A = 8'd8;
	localparam logic [DATA_W-1:0] SECTOR_B = 8'd9;
	localparam logic [DATA_W-1:0] SECTOR_C = 8'd10;
	localparam logic [ADDR_W-1:0] SECTOR_A_ADDR = 24'h078000;
	localparam logic [ADDR_W-1:0] SECTOR_B_ADDR = 24'h07A000;
	localparam logic [ADDR_W-1:0] SECTOR_C_ADDR = 24'h07C000;

	// status byte bits
	localparam int STAT_TOGGLE  = 6;
	localparam int STAT_TIMEOUT = 5;
	localparam int STAT_POLL    = 7;

	// job queue
	localparam int JOB_DEPTH = 4;
	localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

	// back-end step counter, longest job has seven results
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] LAST_PROGRAM = 3'd4;
	localparam logic [STEP_W-1:0] LAST_ERASE   = 3'd6;
	localparam logic [STEP_W-1:0] LAST_SINGLE  = 3'd0;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FIRST,
		PH_POLL,
		PH_RECHECK
	} phase_t;

	typedef enum logic [1:0] {
		OP_PROGRAM,
		OP_ERASE,
		OP_READ,
		OP_DONE
	} job_op_t;

	typedef struct packed {
		job_op_t           op;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] data;
		logic              success;
	} job_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] data;
		logic [DATA_W-1:0] sector;
		logic [DATA_W-1:0] read_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] bus_address;
		logic [DATA_W-1:0] bus_data;
		logic              success;
		logic              last;
	} out_item_t;

endpackage

### rtl/core/ftb_front.sv
// ----------------------------------------------------------------------------
// ftb_front
// accepts commands and status bytes, tracks the polling phase, queues jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftb_front import ftb_pkg::*; #(
	parameter int ADDR_BITS = 24
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     job_full,
	output logic     job_push,
	output job_t     job
);

	localparam int TGT_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

	phase_t            phase_q, phase_d;
	logic              is_erase_q;
	logic [TGT_W-1:0]  tgt_q;
	logic              saved_q;
	logic              accept;
	logic              t6;
	logic              toggled;
	logic              rc_busy;
	logic [ADDR_W-1:0] sector_addr;
	logic [TGT_W-1:0]  tgt_prog;
	logic [TGT_W-1:0]  tgt_erase;

	assign in_ready = !job_full;
	assign accept   = in_valid && in_ready;
	assign t6       = in_item.read_data[STAT_TOGGLE];
	assign toggled  = t6 != saved_q;
	assign rc_busy  = toggled && (!is_erase_q || !in_item.read_data[STAT_POLL]);

	always_comb begin
		case (in_item.sector)
			SECTOR_A: sector_addr = SECTOR_A_ADDR;
			SECTOR_B: sector_addr = SECTOR_B_ADDR;
			SECTOR_C: sector_addr = SECTOR_C_ADDR;
			default:  sector_addr = {in_item.sector, 16'h0000};
		endcase
	end

	assign tgt_prog  = TGT_W'(in_item.address);
	assign tgt_erase = TGT_W'(sector_addr);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (in_item.cmd == CMD_PROGRAM || in_item.cmd == CMD_ERASE)
						phase_d = PH_FIRST;
				end
				PH_FIRST: begin
					if (in_item.cmd == CMD_STATUS)
						phase_d = PH_POLL;
				end
				PH_POLL: begin
					if (in_item.cmd == CMD_STATUS) begin
						if (!toggled)
							phase_d = PH_IDLE;
						else if (in_item.read_data[STAT_TIMEOUT])
							phase_d = PH_RECHECK;
					end
				end
				PH_RECHECK: begin
					if (in_item.cmd == CMD_STATUS)
						phase_d = PH_IDLE;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// job generation
	always_comb begin
		job_push    = 1'b0;
		job.op      = OP_READ;
		job.address = ADDR_W'(tgt_q);
		job.data    = in_item.data;
		job.success = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (in_item.cmd == CMD_PROGRAM) begin
					job_push    = accept;
					job.op      = OP_PROGRAM;
					job.address = ADDR_W'(tgt_prog);
				end else if (in_item.cmd == CMD_ERASE) begin
					job_push    = accept;
					job.op      = OP_ERASE;
					job.address = ADDR_W'(tgt_erase);
				end
			end
			PH_FIRST: begin
				job_push = accept && in_item.cmd == CMD_STATUS;
			end
			PH_POLL: begin
				job_push = accept && in_item.cmd == CMD_STATUS;
				if (!toggled) begin
					job.op      = OP_DONE;
					job.success = 1'b1;
				end
			end
			PH_RECHECK: begin
				job_push    = accept && in_item.cmd == CMD_STATUS;
				job.op      = OP_DONE;
				job.success = !rc_busy;
			end
			default: job_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			is_erase_q <= 1'b0;
			tgt_q      <= '0;
			saved_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (accept && phase_q == PH_IDLE) begin
				if (in_item.cmd == CMD_PROGRAM) begin
					tgt_q      <= tgt_prog;
					is_erase_q <= 1'b0;
				end else if (in_item.cmd == CMD_ERASE) begin
					tgt_q      <= tgt_erase;
					is_erase_q <= 1'b1;
				end
			end
			if (accept && phase_q != PH_IDLE && in_item.cmd == CMD_STATUS)
				saved_q <= t6;
		end
	end

endmodule

### rtl/core/ftb_fifo.sv
// ----------------------------------------------------------------------------
// ftb_fifo
// short job queue between the front and back ends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftb_fifo import ftb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	job_t                 mem_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q;
	logic [JOB_PTR_W-1:0] rd_ptr_q;
	logic [JOB_CNT_W-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = count_q == JOB_CNT_W'(JOB_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### rtl/core/ftb_back.sv
// ----------------------------------------------------------------------------
// ftb_back
// expands queued jobs into flash bus results, one per cycle when out_ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftb_back import ftb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	input  job_t      job_in,
	output logic      job_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	job_t              job_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	out_item_t         out_item_q;
	logic              load;
	logic              emit;
	logic              last_step;
	logic [STEP_W-1:0] last_idx;
	out_item_t         cur;

	always_comb begin
		unique case (job_q.op)
			OP_PROGRAM: last_idx = LAST_PROGRAM;
			OP_ERASE:   last_idx = LAST_ERASE;
			default:    last_idx = LAST_SINGLE;
		endcase
	end

	assign load      = !out_valid_q || out_ready;
	assign emit      = busy_q && load;
	assign last_step = step_q == last_idx;
	assign job_pop   = job_valid && (!busy_q || (emit && last_step));

	// result for the current step
	always_comb begin
		cur.kind        = KIND_WRITE;
		cur.bus_address = job_q.address;
		cur.bus_data    = '0;
		cur.success     = 1'b0;
		cur.last        = last_step;
		unique case (job_q.op)
			OP_PROGRAM: begin
				case (step_q)
					3'd0: begin
						cur.bus_address = UNLOCK_ADDR1;
						cur.bus_data    = UNLOCK_DATA1;
					end
					3'd1: begin
						cur.bus_address = UNLOCK_ADDR2;
						cur.bus_data    = UNLOCK_DATA2;
					end
					3'd2: begin
						cur.bus_address = UNLOCK_ADDR1;
						cur.bus_data    = PROGRAM_DATA;
					end
					3'd3: cur.bus_data = job_q.data;
					default: cur.kind = KIND_READ;
				endcase
			end
			OP_ERASE: begin
				case (step_q)
					3'd0, 3'd3: begin
						cur.bus_address = UNLOCK_ADDR1;
						cur.bus_data    = UNLOCK_DATA1;
					end
					3'd1, 3'd4: begin
						cur.bus_address = UNLOCK_ADDR2;
						cur.bus_data    = UNLOCK_DATA2;
					end
					3'd2: begin
						cur.bus_address = UNLOCK_ADDR1;
						cur.bus_data    = ERASE_SETUP;
					end
					3'd5: cur.bus_data = ERASE_SECTOR;
					default: cur.kind = KIND_READ;
				endcase
			end
			OP_READ: cur.kind = KIND_READ;
			OP_DONE: begin
				cur.kind    = KIND_DONE;
				cur.success = job_q.success;
			end
			default: cur.kind = KIND_READ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (emit && last_step) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_q + 1'b1;
			end
			if (load)
				out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop)
			job_q <= job_in;
		if (emit)
			out_item_q <= cur;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

### rtl/core/flash_toggle_bit_program_erase.sv
// ----------------------------------------------------------------------------
// flash_toggle_bit_program_erase
// an item's job goes through the job queue and back-end job register to the output register
// throughput: program 5 results, erase 7, status byte 1, one per cycle while out_ready
// a new item is taken every cycle while the 4-entry job queue has room
// reset clears polling phase, target, job queue and output valid at once
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "flash_toggle_bit_program_erase_macros.svh"

module flash_toggle_bit_program_erase import ftb_pkg::*; #(
	parameter int ADDR_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	// front to queue
	logic job_push;
	job_t push_job;
	logic job_full;

	// queue to back
	logic job_pop;
	job_t pop_job;
	logic job_empty;

	// result decode for the checks below
	logic res_done;
	logic res_read;
	logic res_write;
	logic res_ok;

	// front: decodes each transfer against the polling phase, owns the
	// target address and last toggle bit, and turns accepted items into jobs as the phase allows
	ftb_front #(
		.ADDR_BITS(ADDR_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.job_full (job_full),
		.job_push (job_push),
		.job      (push_job)
	);

	// queue: lets a long erase sequence drain while more items come in
	ftb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.full     (job_full),
		.pop      (job_pop),
		.pop_job  (pop_job),
		.empty    (job_empty)
	);

	// back: steps through the unlock writes and read/done results of a job,
	// with a registered output that keeps going while downstream takes data
	ftb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!job_empty),
		.job_in    (pop_job),
		.job_pop   (job_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	assign res_done  = out_valid && out_item.kind == KIND_DONE;
	assign res_read  = out_valid && out_item.kind == KIND_READ;
	assign res_write = out_valid && out_item.kind == KIND_WRITE;
	assign res_ok    = out_valid && out_item.success;

	// every single-result job closes its item
	`FTB_ASSERT_IMPL(a_done_is_last, res_done, out_item.last, "done result without last")
	`FTB_ASSERT_IMPL(a_read_is_last, res_read, out_item.last, "read request without last")
	// a bus write is never the last result of its job
	`FTB_ASSERT_IMPL(a_write_not_last, res_write, !out_item.last, "bus write marked last")
	`FTB_ASSERT(a_success_on_done, !res_ok || res_done, "success outside done")

endmodule
